// ----- sv/look_locker_t1_pixel_map_core_assert.svh -----
// Assertion macros used by the pixel map core RTL.
`ifndef LOOK_LOCKER_T1_PIXEL_MAP_CORE_ASSERT_SVH
`define LOOK_LOCKER_T1_PIXEL_MAP_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define LLT1_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define LLT1_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/llt1_pkg.sv -----
// Package with shared types and register indexes of the T1 pixel map.
`timescale 1ns / 1ps
`default_nettype none
package llt1_pkg;

  typedef enum logic {
    CfgMinMag = 1'b0,
    CfgDelay  = 1'b1
  } llt1_cfg_idx_e;

  // Control bits that travel with each pixel through the back half.
  typedef struct packed {
    logic vld;
    logic zero;
    logic dz;
  } llt1_meta_t;

endpackage
`default_nettype wire

// ----- sv/llt1_isqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps
`default_nettype none
module llt1_isqrt #(
  parameter int SW = 16
) (
  input  wire logic            clk_i,
  input  wire logic [2*SW-1:0] rad_i,
  output logic      [SW-1:0]   root_o
);

  localparam int RW = 2 * SW;

  logic [RW-1:0] rad_q  [SW];
  logic [SW+1:0] rem_q  [SW];
  logic [SW-1:0] root_q [SW];

  for (genvar s = 0; s < SW; s++) begin : g_stage
    logic [RW-1:0] rad_in;
    logic [SW+1:0] rem_in;
    logic [SW-1:0] root_in;
    logic [SW+1:0] rem_sh;
    logic [SW+1:0] trial;

    if (s == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // The partial remainder never exceeds twice the partial root.
    assign rem_sh = {rem_in[SW-1:0], rad_in[RW-1:RW-2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      rad_q[s] <= {rad_in[RW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q[s]  <= rem_sh - trial;
        root_q[s] <= {root_in[SW-2:0], 1'b1};
      end else begin
        rem_q[s]  <= rem_sh;
        root_q[s] <= {root_in[SW-2:0], 1'b0};
      end
    end
  end

  assign root_o = root_q[SW-1];

endmodule
`default_nettype wire

// ----- sv/look_locker_t1_pixel_map_core.sv -----
// Top level of the pipelined Look-Locker T1 pixel map.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+-------------------------
//   pixel in | ms_*_i, m0_*_i, rate_*_i               | start && !busy
//   result   | t1_value_o, zeroed_o, saturated_o      | result_valid_o, 1 cycle
//   config   | cfg_idx_i, cfg_wdata_i                 | cfg_we_i
//
// One pixel word is taken every cycle; busy stays low. A result passes through
// the front-end registers, the square roots, the denominator register, the
// divider and the output register. The depth is set by the square root,
// which resolves one root bit per stage, and by the restoring divider, which
// resolves one quotient bit per stage. Reset clears the valid bits and loads
// the register defaults; data registers are not reset. The receiver cannot
// stall, so the pipeline simply advances every cycle.
`timescale 1ns / 1ps
`default_nettype none
module look_locker_t1_pixel_map_core
  import llt1_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 12
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic signed [SAMPLE_WIDTH-1:0] ms_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] ms_im_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] m0_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] m0_im_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rate_re_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] rate_im_i,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [30:0]                    cfg_wdata_i,
  output logic                                result_valid_o,
  output logic [31:0]                         t1_value_o,
  output logic                                zeroed_o,
  output logic                                saturated_o
);

  `include "look_locker_t1_pixel_map_core_assert.svh"

  localparam int SW = SAMPLE_WIDTH;
  localparam int RW = 2 * SW;
  localparam int DW = 2 * SW;
  // The numerator is |M0| scaled up by the fraction bits plus the Q16.16 shift.
  localparam int SH = FRAC_BITS + 16;
  localparam int NW = SW + SH;
  localparam int EW = NW + 33;

  // Configuration registers.
  logic [15:0] min_q;
  logic [30:0] delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= 16'd819;
      delay_q <= '0;
    end else if (cfg_we_i) begin
      case (llt1_cfg_idx_e'(cfg_idx_i))
        CfgMinMag: min_q   <= cfg_wdata_i[15:0];
        CfgDelay:  delay_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Front end: absolute values, then squares, then sums of squares.
  logic [2:0]    fv_q;
  logic [SW-1:0] abs_q [6];
  logic [RW-1:0] sqr_q [6];
  logic [RW-1:0] ms_rad_q, m0_rad_q, rt_rad_q;
  logic [SW-1:0] abs_d [6];
  logic [SW-1:0] raw   [6];

  assign raw[0] = ms_re_i;
  assign raw[1] = ms_im_i;
  assign raw[2] = m0_re_i;
  assign raw[3] = m0_im_i;
  assign raw[4] = rate_re_i;
  assign raw[5] = rate_im_i;

  // The most negative sample folds to its unsigned magnitude.
  for (genvar k = 0; k < 6; k++) begin : g_abs
    assign abs_d[k] = raw[k][SW-1] ? (~raw[k] + 1'b1) : raw[k];
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 6; k++) begin
      abs_q[k] <= abs_d[k];
      sqr_q[k] <= RW'(abs_q[k]) * RW'(abs_q[k]);
    end
    ms_rad_q <= sqr_q[0] + sqr_q[1];
    m0_rad_q <= sqr_q[2] + sqr_q[3];
    rt_rad_q <= sqr_q[4] + sqr_q[5];
  end

  // Magnitudes.
  logic [SW-1:0] ms_mag, m0_mag, rt_mag;
  logic [SW-1:0] sq_vld_q;

  llt1_isqrt #(.SW(SW)) u_sqrt_ms (.clk_i(clk_i), .rad_i(ms_rad_q), .root_o(ms_mag));
  llt1_isqrt #(.SW(SW)) u_sqrt_m0 (.clk_i(clk_i), .rad_i(m0_rad_q), .root_o(m0_mag));
  llt1_isqrt #(.SW(SW)) u_sqrt_rt (.clk_i(clk_i), .rad_i(rt_rad_q), .root_o(rt_mag));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q     <= '0;
      sq_vld_q <= '0;
    end else begin
      fv_q     <= {fv_q[1:0], start & ~busy};
      sq_vld_q <= {sq_vld_q[SW-2:0], fv_q[2]};
    end
  end

  // Denominator stage; the special cases are classified here.
  llt1_meta_t    mul_meta_q;
  logic [DW-1:0] den_q;
  logic [SW-1:0] m0m_q;
  logic [DW-1:0] den_d;
  logic          zero_d;

  assign den_d  = DW'(ms_mag) * DW'(rt_mag);
  assign zero_d = (32'(ms_mag) < 32'(min_q)) || ((m0_mag == '0) && (den_d == '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_meta_q <= '0;
    end else begin
      mul_meta_q <= '{vld: sq_vld_q[SW-1], zero: zero_d, dz: (den_d == '0)};
    end
  end

  always_ff @(posedge clk_i) begin
    den_q <= den_d;
    m0m_q <= m0_mag;
  end

  // Restoring divider, one quotient bit per stage.
  llt1_meta_t    dv_meta_q [NW];
  logic [DW-1:0] dv_rem_q  [NW];
  logic [NW-1:0] dv_q_q    [NW];
  logic [NW-1:0] dv_num_q  [NW];
  logic [DW-1:0] dv_den_q  [NW];

  for (genvar j = 0; j < NW; j++) begin : g_div
    llt1_meta_t    meta_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] q_in;
    logic [NW-1:0] num_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   rem_sh;
    logic          ge;

    if (j == 0) begin : g_first
      assign meta_in = mul_meta_q;
      assign rem_in  = '0;
      assign q_in    = '0;
      assign num_in  = {m0m_q, {SH{1'b0}}};
      assign den_in  = den_q;
    end else begin : g_next
      assign meta_in = dv_meta_q[j-1];
      assign rem_in  = dv_rem_q[j-1];
      assign q_in    = dv_q_q[j-1];
      assign num_in  = dv_num_q[j-1];
      assign den_in  = dv_den_q[j-1];
    end

    assign rem_sh = {rem_in, num_in[NW-1]};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_meta_q[j] <= '0;
      end else begin
        dv_meta_q[j] <= meta_in;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_rem_q[j] <= ge ? DW'(rem_sh - {1'b0, den_in}) : rem_sh[DW-1:0];
      dv_q_q[j]   <= {q_in[NW-2:0], ge};
      dv_num_q[j] <= {num_in[NW-2:0], 1'b0};
      dv_den_q[j] <= den_in;
    end
  end

  // Output stage: overflow check, delay offset and flag selection.
  llt1_meta_t    fin_meta;
  logic [EW-1:0] q_ext;
  logic [32:0]   sum;
  logic          sat;

  assign fin_meta = dv_meta_q[NW-1];
  assign q_ext    = EW'(dv_q_q[NW-1]);
  assign sum      = {1'b0, q_ext[31:0]} + {1'b0, delay_q, 1'b0};
  assign sat      = fin_meta.dz || (|q_ext[EW-1:32]) || sum[32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= fin_meta.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_meta.zero) begin
      t1_value_o  <= '0;
      zeroed_o    <= 1'b1;
      saturated_o <= 1'b0;
    end else begin
      t1_value_o  <= sat ? '1 : sum[31:0];
      zeroed_o    <= 1'b0;
      saturated_o <= sat;
    end
  end

  `LLT1_ASSERT_IMPL(a_flags_excl, result_valid_o, !(zeroed_o && saturated_o), "both flags set")
  `LLT1_ASSERT_IMPL(a_zero_value, result_valid_o && zeroed_o, t1_value_o == '0, "zeroed not 0")
  `LLT1_ASSERT_IMPL(a_sat_value, result_valid_o && saturated_o, t1_value_o == '1, "sat not max")
  `LLT1_ASSERT_NEXT(a_div_to_out, fin_meta.vld, result_valid_o, "result strobe lost")

endmodule
`default_nettype wire
